[hw/rtl/slfs_pkg.sv]
// shared types, codes and reset values for the stair light fade sequencer
// no dependencies; imported by every module of the block but slfs_mean_div
`default_nettype none

package slfs_pkg;

	localparam int OP_W         = 2;
	localparam int DUTY_W       = 8;
	localparam int TIMER_W      = 16;
	localparam int PHASE_CODE_W = 3;
	localparam int THRESH_W     = 10;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 16;

	// input operation codes
	localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
	localparam logic [OP_W-1:0] OP_TRIGGER = 2'd1;
	localparam logic [OP_W-1:0] OP_SAMPLE  = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DARK_ABOVE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FINAL_DUTY = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FADE_STEP  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PRE_FADE   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_EXTENSION  = 3'd6;

	// register reset values
	localparam logic [THRESH_W-1:0] RST_THRESHOLD  = 10'd40;
	localparam logic                RST_DARK_ABOVE = 1'b0;
	localparam logic [DUTY_W-1:0]   RST_FINAL_DUTY = 8'd100;
	localparam logic [7:0]          RST_FADE_STEP  = 8'd20;
	localparam logic [TIMER_W-1:0]  RST_PRE_FADE   = 16'd500;
	localparam logic [TIMER_W-1:0]  RST_SUSTAIN    = 16'd12000;
	localparam logic [TIMER_W-1:0]  RST_EXTENSION  = 16'd8000;

	// phase codes as seen on the result
	localparam logic [PHASE_CODE_W-1:0] PCODE_OFF   = 3'd0;
	localparam logic [PHASE_CODE_W-1:0] PCODE_ARMED = 3'd1;
	localparam logic [PHASE_CODE_W-1:0] PCODE_WAIT  = 3'd2;
	localparam logic [PHASE_CODE_W-1:0] PCODE_UP    = 3'd3;
	localparam logic [PHASE_CODE_W-1:0] PCODE_HOLD  = 3'd4;
	localparam logic [PHASE_CODE_W-1:0] PCODE_DOWN  = 3'd5;

	typedef enum logic [5:0] {
		PH_OFF   = 6'b000001,
		PH_ARMED = 6'b000010,
		PH_WAIT  = 6'b000100,
		PH_UP    = 6'b001000,
		PH_HOLD  = 6'b010000,
		PH_DOWN  = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [THRESH_W-1:0] threshold;
		logic                dark_above;
		logic [DUTY_W-1:0]   final_duty;
		logic [7:0]          fade_step;
		logic [TIMER_W-1:0]  pre_fade;
		logic [TIMER_W-1:0]  sustain;
		logic [TIMER_W-1:0]  extension;
	} cfg_t;

	// one item leaving the input register
	typedef struct packed {
		logic            fire;
		logic [OP_W-1:0] op;
	} step_t;

	function automatic logic [PHASE_CODE_W-1:0] phase_code(input phase_t ph);
		logic [PHASE_CODE_W-1:0] code;
		case (ph)
			PH_OFF:   code = PCODE_OFF;
			PH_ARMED: code = PCODE_ARMED;
			PH_WAIT:  code = PCODE_WAIT;
			PH_UP:    code = PCODE_UP;
			PH_HOLD:  code = PCODE_HOLD;
			PH_DOWN:  code = PCODE_DOWN;
			default:  code = PCODE_OFF;
		endcase
		return code;
	endfunction

	function automatic logic relay_closed(input phase_t ph);
		return (ph == PH_WAIT) || (ph == PH_UP) || (ph == PH_HOLD) || (ph == PH_DOWN);
	endfunction

endpackage

`default_nettype wire

[hw/rtl/slfs_cfg_regs.sv]
// configuration register file of the stair light fade sequencer
// depends on slfs_pkg
`default_nettype none

module slfs_cfg_regs (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire [slfs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire [slfs_pkg::CFG_DATA_W-1:0] cfg_data,
	output slfs_pkg::cfg_t               cfg
);
	import slfs_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold  <= RST_THRESHOLD;
			cfg_q.dark_above <= RST_DARK_ABOVE;
			cfg_q.final_duty <= RST_FINAL_DUTY;
			cfg_q.fade_step  <= RST_FADE_STEP;
			cfg_q.pre_fade   <= RST_PRE_FADE;
			cfg_q.sustain    <= RST_SUSTAIN;
			cfg_q.extension  <= RST_EXTENSION;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_THRESHOLD:  cfg_q.threshold  <= cfg_data[THRESH_W-1:0];
				REG_DARK_ABOVE: cfg_q.dark_above <= cfg_data[0];
				REG_FINAL_DUTY: cfg_q.final_duty <= cfg_data[DUTY_W-1:0];
				REG_FADE_STEP:  cfg_q.fade_step  <= cfg_data[7:0];
				REG_PRE_FADE:   cfg_q.pre_fade   <= cfg_data[TIMER_W-1:0];
				REG_SUSTAIN:    cfg_q.sustain    <= cfg_data[TIMER_W-1:0];
				REG_EXTENSION:  cfg_q.extension  <= cfg_data[TIMER_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

[hw/rtl/slfs_mean_div.sv]
// divides the light sample sum by the sample count
// multiply by a rounded-up reciprocal, exact for every sum of SUM_W bits whose mean fits in MEAN_W bits
// depends on nothing outside this file
`default_nettype none

module slfs_mean_div #(
	parameter int COUNT  = 10,
	parameter int SUM_W  = 14,
	parameter int MEAN_W = 10
) (
	input  wire  [SUM_W-1:0]  sum,
	output logic [MEAN_W-1:0] mean
);
	localparam int SHIFT  = SUM_W + $clog2(COUNT);
	localparam int PROD_W = SHIFT + MEAN_W;
	localparam longint unsigned RECIP = ((64'd1 << SHIFT) + COUNT - 1) / COUNT;
	localparam logic [PROD_W-1:0] RECIP_L = PROD_W'(RECIP);

	logic [PROD_W-1:0] prod;

	assign prod = PROD_W'(sum) * RECIP_L;
	assign mean = prod[SHIFT +: MEAN_W];

endmodule

`default_nettype wire

[hw/rtl/slfs_light_avg.sv]
// light sample ring with running sum
// depends on slfs_pkg
`default_nettype none

module slfs_light_avg #(
	parameter int SAMPLE_COUNT = 10,
	parameter int SAMPLE_BITS  = 10,
	parameter int SUM_W        = 14
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  slfs_pkg::step_t        step,
	input  wire [SAMPLE_BITS-1:0]  sample,
	output logic [SUM_W-1:0]       sum_cur,
	output logic [SUM_W-1:0]       sum_nxt
);
	import slfs_pkg::*;

	localparam int POS_W = (SAMPLE_COUNT > 1) ? $clog2(SAMPLE_COUNT) : 1;
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(SAMPLE_COUNT - 1);

	logic [SAMPLE_BITS-1:0] ring_q [SAMPLE_COUNT];
	logic [POS_W-1:0]       pos_q;
	logic [SUM_W-1:0]       sum_q;
	logic                   wr_en;
	logic [POS_W-1:0]       pos_nxt;

	assign wr_en   = step.fire && (step.op == OP_SAMPLE);
	assign pos_nxt = (pos_q == POS_LAST) ? '0 : pos_q + POS_W'(1);
	assign sum_cur = sum_q;
	// the old entry is part of the sum, so the difference never goes negative
	assign sum_nxt = wr_en ? (sum_q - SUM_W'(ring_q[pos_q]) + SUM_W'(sample)) : sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SAMPLE_COUNT; i++) begin
				ring_q[i] <= '0;
			end
			pos_q <= '0;
			sum_q <= '0;
		end else if (wr_en) begin
			ring_q[pos_q] <= sample;
			pos_q         <= pos_nxt;
			sum_q         <= sum_nxt;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/slfs_phase_ctrl.sv]
// light cycle state machine: arm, dark check, pre-fade wait, fades and hold
// depends on slfs_pkg
`default_nettype none

module slfs_phase_ctrl #(
	parameter int MEAN_W = 10
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  slfs_pkg::cfg_t                cfg,
	input  slfs_pkg::step_t               step,
	input  wire [MEAN_W-1:0]              mean,
	output logic [slfs_pkg::DUTY_W-1:0]   duty_nxt,
	output slfs_pkg::phase_t              phase_nxt
);
	import slfs_pkg::*;

	localparam int CMP_W = (MEAN_W > THRESH_W) ? MEAN_W : THRESH_W;

	phase_t              phase_q;
	logic [DUTY_W-1:0]   duty_q;
	logic [TIMER_W-1:0]  timer_q;
	logic [TIMER_W-1:0]  timer_nxt;
	logic [TIMER_W-1:0]  timer_dec;
	logic                timer_done;
	logic [DUTY_W-1:0]   duty_inc;
	logic [DUTY_W-1:0]   duty_dec;
	logic [TIMER_W:0]    ext_sum;
	logic [TIMER_W-1:0]  fade_step_w;
	logic [CMP_W-1:0]    mean_x;
	logic [CMP_W-1:0]    thr_x;
	logic                dark;

	assign mean_x      = CMP_W'(mean);
	assign thr_x       = CMP_W'(cfg.threshold);
	assign dark        = cfg.dark_above ? (mean_x >= thr_x) : (mean_x <= thr_x);
	assign timer_dec   = (timer_q != '0) ? timer_q - TIMER_W'(1) : '0;
	assign timer_done  = (timer_q <= TIMER_W'(1));
	assign duty_inc    = duty_q + DUTY_W'(1);
	assign duty_dec    = duty_q - DUTY_W'(1);
	assign ext_sum     = {1'b0, timer_q} + {1'b0, cfg.extension};
	assign fade_step_w = TIMER_W'(cfg.fade_step);

	always_comb begin
		phase_nxt = phase_q;
		duty_nxt  = duty_q;
		timer_nxt = timer_q;
		if (step.fire) begin
			case (step.op)
				OP_TICK: begin
					case (phase_q)
						PH_ARMED: begin
							if (dark) begin
								phase_nxt = PH_WAIT;
								timer_nxt = cfg.pre_fade;
							end
						end
						PH_WAIT: begin
							if (!timer_done) begin
								timer_nxt = timer_dec;
							end else if (duty_q >= cfg.final_duty) begin
								phase_nxt = PH_HOLD;
								timer_nxt = cfg.sustain;
							end else begin
								phase_nxt = PH_UP;
								timer_nxt = fade_step_w;
							end
						end
						PH_UP: begin
							// final duty may have been lowered under the ramp
							if (duty_q >= cfg.final_duty) begin
								phase_nxt = PH_HOLD;
								timer_nxt = cfg.sustain;
							end else if (timer_done) begin
								duty_nxt = duty_inc;
								if (duty_inc >= cfg.final_duty) begin
									phase_nxt = PH_HOLD;
									timer_nxt = cfg.sustain;
								end else begin
									timer_nxt = fade_step_w;
								end
							end else begin
								timer_nxt = timer_dec;
							end
						end
						PH_HOLD: begin
							if (timer_done) begin
								phase_nxt = PH_DOWN;
								timer_nxt = fade_step_w;
							end else begin
								timer_nxt = timer_dec;
							end
						end
						PH_DOWN: begin
							if (duty_q == '0) begin
								phase_nxt = PH_OFF;
								timer_nxt = '0;
							end else if (timer_done) begin
								duty_nxt = duty_dec;
								if (duty_dec == '0) begin
									phase_nxt = PH_OFF;
									timer_nxt = '0;
								end else begin
									timer_nxt = fade_step_w;
								end
							end else begin
								timer_nxt = timer_dec;
							end
						end
						default: ;
					endcase
				end
				OP_TRIGGER: begin
					if (phase_q == PH_OFF) begin
						phase_nxt = PH_ARMED;
					end else if (phase_q == PH_HOLD) begin
						// extend the remaining hold, capped at the full sustain time
						if ((timer_q >= cfg.sustain) || (ext_sum >= {1'b0, cfg.sustain})) begin
							timer_nxt = cfg.sustain;
						end else begin
							timer_nxt = ext_sum[TIMER_W-1:0];
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_OFF;
			duty_q  <= '0;
			timer_q <= '0;
		end else begin
			phase_q <= phase_nxt;
			duty_q  <= duty_nxt;
			timer_q <= timer_nxt;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/stair_light_fade_sequencer.sv]
// stair light fade sequencer, top level
// depends on slfs_pkg, slfs_cfg_regs, slfs_light_avg, slfs_mean_div, slfs_phase_ctrl
//
// usage:
//   input stream (s_*): one item per transfer; s_tuser carries the operation
//   (tick, motion trigger, light sample), s_tdata the light sample.
//   output stream (m_*): exactly one result per input item, in order: duty,
//   relay state, phase code and mean light after that item is applied.
//   config channel (cfg_*): one register write per transfer, always ready;
//   write only while no item is in flight.
// timing:
//   an item taken into the input register reaches m_tvalid through the state
//   update into the result register and the mean into the output register.
//   one item per cycle is sustained while m_tready stays high; the phase state
//   machine and the sample ring both update as the item leaves the input register.
// stalls:
//   each stage moves on when the one after it is empty or moving, so bubbles
//   are squeezed out and items are still taken while a result waits; with all
//   three stages full and m_tready low, s_tready drops.
// reset:
//   arst_n clears the ring, the sum, the phase (off), duty and timer, and
//   loads the register defaults; no result is pending after reset.
`default_nettype none

module stair_light_fade_sequencer #(
	parameter int SAMPLE_COUNT = 10,
	parameter int SAMPLE_BITS  = 10,
	localparam int IN_W  = ((SAMPLE_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((12 + SAMPLE_BITS + 7) / 8) * 8
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            s_tvalid,
	output logic                           s_tready,
	input  wire [slfs_pkg::OP_W-1:0]       s_tuser,   // operation
	input  wire [IN_W-1:0]                 s_tdata,   // light_sample, zero pad
	output logic                           m_tvalid,
	input  wire                            m_tready,
	output logic [OUT_W-1:0]               m_tdata,   // duty, relay_on, phase, mean_light, pad
	input  wire                            cfg_valid,
	output logic                           cfg_ready,
	input  wire [slfs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire [slfs_pkg::CFG_DATA_W-1:0] cfg_data
);
	import slfs_pkg::*;

	localparam int SUM_W  = $clog2(SAMPLE_COUNT * ((1 << SAMPLE_BITS) - 1) + 1);

	cfg_t                    cfg;
	step_t                   step;

	logic                    valid_s1;
	logic [OP_W-1:0]         op_s1;
	logic [SAMPLE_BITS-1:0]  sample_s1;

	logic                    valid_s2;
	logic [DUTY_W-1:0]       duty_s2;
	phase_t                  phase_s2;
	logic [SUM_W-1:0]        sum_s2;

	logic                    valid_s3;
	logic [OUT_W-1:0]        data_s3;

	logic                    adv_s3;
	logic                    adv_s2;
	logic                    fire_s1;

	logic [SUM_W-1:0]        sum_cur;
	logic [SUM_W-1:0]        sum_nxt;
	logic [SAMPLE_BITS-1:0]  mean_cur;
	logic [SAMPLE_BITS-1:0]  mean_s2;
	logic [DUTY_W-1:0]       duty_nxt;
	phase_t                  phase_nxt;

	// a stage moves on when the next one is empty or moving
	assign adv_s3   = !valid_s3 || m_tready;
	assign adv_s2   = !valid_s2 || adv_s3;
	assign s_tready = !valid_s1 || adv_s2;
	assign fire_s1  = valid_s1 && adv_s2;

	assign step.fire = fire_s1;
	assign step.op   = op_s1;

	assign m_tvalid = valid_s3;
	assign m_tdata  = data_s3;

	slfs_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	slfs_light_avg #(
		.SAMPLE_COUNT (SAMPLE_COUNT),
		.SAMPLE_BITS  (SAMPLE_BITS),
		.SUM_W        (SUM_W)
	) u_light_avg (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.sample  (sample_s1),
		.sum_cur (sum_cur),
		.sum_nxt (sum_nxt)
	);

	// mean of the stored samples as the dark check sees it
	slfs_mean_div #(
		.COUNT  (SAMPLE_COUNT),
		.SUM_W  (SUM_W),
		.MEAN_W (SAMPLE_BITS)
	) u_mean_cur (
		.sum  (sum_cur),
		.mean (mean_cur)
	);

	// mean after the item, for the result
	slfs_mean_div #(
		.COUNT  (SAMPLE_COUNT),
		.SUM_W  (SUM_W),
		.MEAN_W (SAMPLE_BITS)
	) u_mean_out (
		.sum  (sum_s2),
		.mean (mean_s2)
	);

	slfs_phase_ctrl #(
		.MEAN_W (SAMPLE_BITS)
	) u_phase_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.step      (step),
		.mean      (mean_cur),
		.duty_nxt  (duty_nxt),
		.phase_nxt (phase_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1     <= s_tuser;
			sample_s1 <= s_tdata[SAMPLE_BITS-1:0];
		end
		if (fire_s1) begin
			duty_s2  <= duty_nxt;
			phase_s2 <= phase_nxt;
			sum_s2   <= sum_nxt;
		end
		if (valid_s2 && adv_s3) begin
			data_s3 <= OUT_W'({mean_s2, phase_code(phase_s2), relay_closed(phase_s2), duty_s2});
		end
	end

endmodule

`default_nettype wire

[hw/rtl/slfs_checker.sv]
// port-level checks of the stair light fade sequencer output stream
// depends on slfs_pkg; bound to the top level at the end of this file
`default_nettype none

module slfs_checker #(
	parameter int OUT_W = 24
) (
	input wire             clk,
	input wire             arst_n,
	input wire             m_tvalid,
	input wire             m_tready,
	input wire [OUT_W-1:0] m_tdata
);
	import slfs_pkg::*;

	logic [DUTY_W-1:0]       duty;
	logic                    relay;
	logic [PHASE_CODE_W-1:0] ph;

	assign duty  = m_tdata[DUTY_W-1:0];
	assign relay = m_tdata[DUTY_W];
	assign ph    = m_tdata[DUTY_W+1 +: PHASE_CODE_W];

	// a stalled result holds
	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (ph <= PCODE_DOWN))
		else $error("phase code out of range");

	a_relay_phase: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (relay == ((ph == PCODE_WAIT) || (ph == PCODE_UP) ||
			(ph == PCODE_HOLD) || (ph == PCODE_DOWN))))
		else $error("relay state disagrees with phase");

	// lamp is dark until the fade in starts
	a_dark_duty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && ((ph == PCODE_OFF) || (ph == PCODE_ARMED) || (ph == PCODE_WAIT))
		|-> (duty == '0))
		else $error("nonzero duty outside the fades and hold");

endmodule

bind stair_light_fade_sequencer slfs_checker #(
	.OUT_W (OUT_W)
) u_slfs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

[sim/tb.sv]
// self-checking testbench for the stair light fade sequencer
// depends on slfs_pkg and stair_light_fade_sequencer; holds its own model of the lamp state
// directed tests first, then random light cycles with random idling on both streams
`default_nettype none

module tb;
	import slfs_pkg::*;

	localparam int SAMPLE_COUNT  = 10;
	localparam int SAMPLE_BITS   = 10;
	localparam int IN_W          = 16;
	localparam int OUT_W         = 24;
	localparam int GAP_MAX       = 14;
	localparam int IDLE_LIMIT    = 2000;
	localparam int SETTLE_CYCLES = 6;
	localparam int RANDOM_ITEMS  = 540;

	// operation code with no function
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [DUTY_W-1:0]       duty;
		logic                    relay_on;
		logic [PHASE_CODE_W-1:0] phase;
		logic [SAMPLE_BITS-1:0]  mean_light;
	} lamp_view_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [OP_W-1:0]       s_tuser   = OP_TICK;
	logic [IN_W-1:0]       s_tdata   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_W-1:0]      m_tdata;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_THRESHOLD;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// model of the lamp: registers, phase, duty, timer and light ring
	cfg_t                    lamp_cfg;
	logic [PHASE_CODE_W-1:0] lamp_phase;
	logic [DUTY_W-1:0]       lamp_duty;
	logic [TIMER_W-1:0]      lamp_timer;
	logic [SAMPLE_BITS-1:0]  ring_store [SAMPLE_COUNT];
	int                      ring_slot;
	logic [13:0]             ring_total;
	lamp_view_t              expected_views [$];

	int error_count = 0;
	int items_sent  = 0;
	int ready_wait  = 0;
	int idle_cycles = 0;
	bit no_gaps     = 1'b0;

	always #1 clk = ~clk;

	stair_light_fade_sequencer #(
		.SAMPLE_COUNT(SAMPLE_COUNT),
		.SAMPLE_BITS (SAMPLE_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	function automatic int pick_gap();
		if (no_gaps || $urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(0, GAP_MAX);
	endfunction

	function automatic void reset_lamp_model();
		lamp_cfg = '{threshold: RST_THRESHOLD, dark_above: RST_DARK_ABOVE,
			final_duty: RST_FINAL_DUTY, fade_step: RST_FADE_STEP, pre_fade: RST_PRE_FADE,
			sustain: RST_SUSTAIN, extension: RST_EXTENSION};
		lamp_phase = PCODE_OFF;
		lamp_duty  = '0;
		lamp_timer = '0;
		foreach (ring_store[i])
			ring_store[i] = '0;
		ring_slot  = 0;
		ring_total = '0;
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] ring_mean();
		logic [13:0] q;
		q = 14'(ring_total / SAMPLE_COUNT);
		return q[SAMPLE_BITS-1:0];
	endfunction

	// one tick off the timer, true once it has run out
	function automatic logic timer_expired();
		if (lamp_timer != '0)
			lamp_timer = lamp_timer - TIMER_W'(1);
		return lamp_timer == '0;
	endfunction

	function automatic void start_hold();
		lamp_phase = PCODE_HOLD;
		lamp_timer = lamp_cfg.sustain;
	endfunction

	function automatic void start_fade_in();
		if (lamp_duty >= lamp_cfg.final_duty) begin
			start_hold();
		end else begin
			lamp_phase = PCODE_UP;
			lamp_timer = TIMER_W'(lamp_cfg.fade_step);
		end
	endfunction

	function automatic void start_off();
		lamp_phase = PCODE_OFF;
		lamp_timer = '0;
	endfunction

	function automatic void lamp_tick();
		logic [SAMPLE_BITS-1:0] mean;
		logic dark;
		mean = ring_mean();
		dark = lamp_cfg.dark_above ? (mean >= lamp_cfg.threshold) : (mean <= lamp_cfg.threshold);
		case (lamp_phase)
			PCODE_ARMED: begin
				if (dark) begin
					lamp_phase = PCODE_WAIT;
					lamp_timer = lamp_cfg.pre_fade;
				end
			end
			PCODE_WAIT: begin
				if (timer_expired())
					start_fade_in();
			end
			PCODE_UP: begin
				// final duty may have been lowered under the current duty
				if (lamp_duty >= lamp_cfg.final_duty) begin
					start_hold();
				end else if (timer_expired()) begin
					lamp_duty  = lamp_duty + DUTY_W'(1);
					lamp_timer = TIMER_W'(lamp_cfg.fade_step);
					if (lamp_duty >= lamp_cfg.final_duty)
						start_hold();
				end
			end
			PCODE_HOLD: begin
				if (timer_expired()) begin
					lamp_phase = PCODE_DOWN;
					lamp_timer = TIMER_W'(lamp_cfg.fade_step);
				end
			end
			PCODE_DOWN: begin
				if (lamp_duty == '0) begin
					start_off();
				end else if (timer_expired()) begin
					lamp_duty  = lamp_duty - DUTY_W'(1);
					lamp_timer = TIMER_W'(lamp_cfg.fade_step);
					if (lamp_duty == '0)
						start_off();
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void lamp_trigger();
		if (lamp_phase == PCODE_OFF) begin
			lamp_phase = PCODE_ARMED;
		end else if (lamp_phase == PCODE_HOLD) begin
			// retrigger extends the hold, never past the full sustain time
			if (lamp_timer >= lamp_cfg.sustain ||
					lamp_cfg.extension >= lamp_cfg.sustain - lamp_timer)
				lamp_timer = lamp_cfg.sustain;
			else
				lamp_timer = lamp_timer + lamp_cfg.extension;
		end
	endfunction

	function automatic void lamp_sample(input logic [SAMPLE_BITS-1:0] smp);
		ring_total = ring_total - 14'(ring_store[ring_slot]) + 14'(smp);
		ring_store[ring_slot] = smp;
		ring_slot = (ring_slot == SAMPLE_COUNT - 1) ? 0 : ring_slot + 1;
	endfunction

	function automatic void predict_lamp(input logic [OP_W-1:0] op,
			input logic [SAMPLE_BITS-1:0] smp);
		lamp_view_t view;
		case (op)
			OP_TICK:    lamp_tick();
			OP_TRIGGER: lamp_trigger();
			OP_SAMPLE:  lamp_sample(smp);
			default: ;
		endcase
		view.duty       = lamp_duty;
		view.relay_on   = (lamp_phase >= PCODE_WAIT) && (lamp_phase <= PCODE_DOWN);
		view.phase      = lamp_phase;
		view.mean_light = ring_mean();
		expected_views.push_back(view);
	endfunction

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		case (idx)
			REG_THRESHOLD:  lamp_cfg.threshold  = val[THRESH_W-1:0];
			REG_DARK_ABOVE: lamp_cfg.dark_above = val[0];
			REG_FINAL_DUTY: lamp_cfg.final_duty = val[DUTY_W-1:0];
			REG_FADE_STEP:  lamp_cfg.fade_step  = val[7:0];
			REG_PRE_FADE:   lamp_cfg.pre_fade   = val;
			REG_SUSTAIN:    lamp_cfg.sustain    = val;
			REG_EXTENSION:  lamp_cfg.extension  = val;
			default: ;
		endcase
	endfunction

	// entered at a clock edge; valid stays high when the next item follows with no gap
	task automatic send_item(input logic [OP_W-1:0] op, input logic [SAMPLE_BITS-1:0] smp);
		int gap;
		gap = pick_gap();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {{(IN_W - SAMPLE_BITS){1'b0}}, smp};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_lamp(op, smp);
		items_sent++;
	endtask

	task automatic run_ticks(input int count);
		repeat (count)
			send_item(OP_TICK, SAMPLE_BITS'($urandom_range(0, 1023)));
	endtask

	// stop sending and let every result drain before touching registers
	task automatic settle();
		s_tvalid <= 1'b0;
		while (expected_views.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		apply_reg(idx, val);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_regs(input int thr, input int above, input int fin, input int step,
			input int pre, input int sus, input int ext);
		settle();
		write_reg(REG_THRESHOLD, CFG_DATA_W'(thr));
		write_reg(REG_DARK_ABOVE, CFG_DATA_W'(above));
		write_reg(REG_FINAL_DUTY, CFG_DATA_W'(fin));
		write_reg(REG_FADE_STEP, CFG_DATA_W'(step));
		write_reg(REG_PRE_FADE, CFG_DATA_W'(pre));
		write_reg(REG_SUSTAIN, CFG_DATA_W'(sus));
		write_reg(REG_EXTENSION, CFG_DATA_W'(ext));
	endtask

	// register defaults: unused code, sample extremes, ring wrap, an arming trigger and an ignored one
	task automatic test_idle_operations();
		send_item(OP_UNUSED, 10'h3FF);
		send_item(OP_TICK, 10'h000);
		send_item(OP_SAMPLE, 10'h3FF);
		send_item(OP_SAMPLE, 10'h000);
		send_item(OP_SAMPLE, 10'h2AA);
		send_item(OP_SAMPLE, 10'h155);
		send_item(OP_TRIGGER, 10'h3FF);
		send_item(OP_TRIGGER, 10'h000);
		send_item(OP_TICK, 10'h000);
		// wrap the ring and overwrite the first slot, still bright
		repeat (7) send_item(OP_SAMPLE, 10'h000);
		send_item(OP_TICK, 10'h000);
	endtask

	task automatic test_full_light_cycle();
		load_regs(1023, 0, 3, 1, 0, 3, 1);
		send_item(OP_TICK, 10'h000);
		send_item(OP_TRIGGER, 10'h000);
		run_ticks(3);
		send_item(OP_TRIGGER, 10'h000);
		run_ticks(2);
		send_item(OP_TRIGGER, 10'h000);
		send_item(OP_TICK, 10'h000);
		send_item(OP_TRIGGER, 10'h000);
		run_ticks(12);
	endtask

	// zero step, zero pre-fade, zero sustain and a final duty already met
	task automatic test_zero_timings();
		load_regs(1023, 0, 0, 0, 0, 0, 0);
		send_item(OP_TRIGGER, 10'h000);
		run_ticks(5);
		settle();
		write_reg(REG_FINAL_DUTY, 16'd2);
		send_item(OP_TRIGGER, 10'h000);
		run_ticks(8);
	endtask

	task automatic test_hold_extension();
		load_regs(1023, 0, 1, 1, 0, 1000, 65535);
		send_item(OP_TRIGGER, 10'h000);
		run_ticks(4);
		send_item(OP_TRIGGER, 10'h000);
		send_item(OP_TICK, 10'h000);
		// sustain below the running hold timer: retrigger clamps to it
		settle();
		write_reg(REG_SUSTAIN, 16'd10);
		send_item(OP_TRIGGER, 10'h000);
		run_ticks(3);
		settle();
		write_reg(REG_EXTENSION, 16'd2);
		send_item(OP_TRIGGER, 10'h000);
		settle();
		write_reg(REG_SUSTAIN, 16'd65535);
		run_ticks(14);
	endtask

	task automatic test_fade_in_cut_short();
		load_regs(1023, 0, 255, 1, 0, 5, 0);
		send_item(OP_TRIGGER, 10'h000);
		run_ticks(6);
		settle();
		write_reg(REG_FINAL_DUTY, 16'd1);
		run_ticks(16);
	endtask

	task automatic test_dark_above_threshold();
		load_regs(1023, 1, 4, 255, 65535, 2, 65535);
		send_item(OP_TRIGGER, 10'h000);
		send_item(OP_TICK, 10'h000);
		settle();
		write_reg(REG_FADE_STEP, 16'd1);
		write_reg(REG_PRE_FADE, 16'd2);
		repeat (SAMPLE_COUNT) send_item(OP_SAMPLE, 10'h3FF);
		run_ticks(8);
		send_item(OP_TRIGGER, 10'h000);
		run_ticks(12);
	endtask

	task automatic randomize_regs();
		int thr;
		thr = $urandom_range(0, 1023);
		if ($urandom_range(0, 3) == 0)
			thr = $urandom_range(0, 1) ? 1023 : 0;
		load_regs(thr, $urandom_range(0, 1),
			($urandom_range(0, 15) == 0) ? 255 : $urandom_range(1, 6),
			$urandom_range(1, 3), $urandom_range(0, 4), $urandom_range(1, 10),
			($urandom_range(0, 7) == 0) ? 65535 : $urandom_range(0, 10));
	endtask

	// random light cycles: samples, a trigger, then mostly ticks with noise mixed in
	task automatic test_random_cycles();
		int stop_at;
		int pick;
		bit dim;
		logic [OP_W-1:0] op;
		stop_at = items_sent + RANDOM_ITEMS;
		while (items_sent < stop_at) begin
			randomize_regs();
			no_gaps = ($urandom_range(0, 3) == 0);
			dim = $urandom_range(0, 1);
			repeat ($urandom_range(0, 12))
				send_item(OP_SAMPLE, dim ? SAMPLE_BITS'($urandom_range(0, 63)) :
					SAMPLE_BITS'($urandom_range(0, 1023)));
			send_item(OP_TRIGGER, SAMPLE_BITS'($urandom_range(0, 1023)));
			repeat ($urandom_range(20, 60)) begin
				pick = $urandom_range(0, 99);
				if (pick < 60)
					op = OP_TICK;
				else if (pick < 70)
					op = OP_TRIGGER;
				else if (pick < 95)
					op = OP_SAMPLE;
				else
					op = OP_UNUSED;
				send_item(op, SAMPLE_BITS'($urandom_range(0, 1023)));
			end
		end
		no_gaps = 1'b0;
	endtask

	task automatic compare_field(input string field_name, input int want, input int got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", field_name, want, got);
			error_count++;
		end
	endtask

	// result side: check each transfer, then draw a stall before the next one
	always @(posedge clk) begin
		lamp_view_t want;
		int stall;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_views.size() == 0) begin
					$error("result with nothing expected: m_tdata %h", m_tdata);
					error_count++;
				end else begin
					want = expected_views.pop_front();
					compare_field("duty", want.duty, m_tdata[7:0]);
					compare_field("relay_on", want.relay_on, m_tdata[8]);
					compare_field("phase", want.phase, m_tdata[11:9]);
					compare_field("mean_light", want.mean_light, m_tdata[21:12]);
				end
				stall = pick_gap();
				if (stall != 0) begin
					m_tready   <= 1'b0;
					ready_wait <= stall;
				end
			end else if (!m_tready) begin
				if (ready_wait <= 1)
					m_tready <= 1'b1;
				else
					ready_wait <= ready_wait - 1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		reset_lamp_model();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_operations();
		test_full_light_cycle();
		test_zero_timings();
		test_hold_extension();
		test_fade_in_cut_short();
		test_dark_above_threshold();
		test_random_cycles();
		settle();
		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

`default_nettype wire
